/* hw/rtl/mcg_pkg.sv */
// Package: shared types and constants for the moonlight color grade pixel block.
package mcg_pkg;

  // Pixel and result payloads.
  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } result_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_RED_ADJUST   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_GREEN_ADJUST = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_BLUE_ADJUST  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_CONTRAST     = 8'd3;

  // Constants.
  localparam int unsigned NumChan = 3;
  localparam logic signed [31:0] CONTRAST_RESET = 32'sh0001_0000;
  localparam logic [15:0] CHAN_MAX = 16'hFFFF;

endpackage

/* hw/rtl/moonlight_color_grade_pixel.sv */
// Top level: pipelined moonlight color grade of one RGBA pixel per clock.
// A pixel is accepted on any edge with start high; busy is never raised.
// The result strobe done marks a pixel leaving the last stage; throughput is
// one pixel per clock.
// The eleven stages are set by splitting the wide products into 32-bit partials.
// Synchronous reset clears the valid bits and loads identity settings (contrast 1.0).
module moonlight_color_grade_pixel
  import mcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pixel_t              pixel,
  output logic                done,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]         cfg_data
);

  // Configuration registers.
  logic signed [31:0] adj [NumChan];
  logic signed [31:0] contrast;

  // Stage valid bits; bit 0 is stage 1.
  logic [10:0] vld;

  // Stage payloads.
  logic [15:0] s1_ch [NumChan];
  logic [15:0] s1_mn, s1_mx;
  logic [15:0] s2_ch [NumChan];
  logic signed [47:0] s2_kmn [NumChan];
  logic signed [47:0] s2_kmx [NumChan];
  logic [31:0] s2_keep [NumChan];
  logic signed [48:0] s3_t1 [NumChan];
  logic signed [47:0] s3_kmx [NumChan];
  logic [31:0] s3_keep [NumChan];
  logic signed [63:0] s4_pp0 [NumChan];
  logic signed [48:0] s4_pp1 [NumChan];
  logic signed [47:0] s4_kmx [NumChan];
  logic [31:0] s4_keep [NumChan];
  logic [81:0] s5_n2 [NumChan];
  logic [31:0] s5_keep [NumChan];
  logic signed [63:0] s6_q0 [NumChan];
  logic signed [63:0] s6_q1 [NumChan];
  logic signed [49:0] s6_q2 [NumChan];
  logic [31:0] s6_keep [NumChan];
  logic [113:0] s7_n3 [NumChan];
  logic [31:0] s7_keep [NumChan];
  logic [47:0] s8_p0 [NumChan];
  logic [47:0] s8_p1 [NumChan];
  logic [47:0] s8_p2 [NumChan];
  logic signed [34:0] s8_p3 [NumChan];
  logic [31:0] s8_keep [NumChan];
  logic [81:0] s9_lower [NumChan];
  logic [67:0] s9_upper [NumChan];
  logic [NumChan-1:0] s10_neg, s10_ovf;
  logic [31:0] s10_x [NumChan];
  logic [15:0] s11_res [NumChan];
  logic [15:0] alpha [11];

  // Combinational helpers.
  logic [15:0] in_ch [NumChan];
  logic [15:0] in_mn, in_mx;
  logic [127:0] s10_n [NumChan];
  logic [15:0] s11_q0 [NumChan];
  logic [16:0] s11_rem [NumChan];
  logic [15:0] s11_q [NumChan];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumChan; i++) begin
        adj[i] <= '0;
      end
      contrast <= CONTRAST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED_ADJUST:   adj[0]   <= cfg_data;
        REG_GREEN_ADJUST: adj[1]   <= cfg_data;
        REG_BLUE_ADJUST:  adj[2]   <= cfg_data;
        REG_CONTRAST:     contrast <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[9:0], start && !busy};
    end
  end

  // Minimum and maximum of the color channels at the input.
  always_comb begin
    in_ch[0] = pixel.red_in;
    in_ch[1] = pixel.green_in;
    in_ch[2] = pixel.blue_in;
    in_mn = in_ch[0];
    in_mx = in_ch[0];
    for (int i = 1; i < NumChan; i++) begin
      if (in_ch[i] < in_mn) in_mn = in_ch[i];
      if (in_ch[i] > in_mx) in_mx = in_ch[i];
    end
  end

  // Alpha rides alongside every stage.
  always_ff @(posedge clk) begin
    alpha[0] <= pixel.alpha_in;
    for (int s = 1; s < 11; s++) begin
      alpha[s] <= alpha[s-1];
    end
  end

  // Stages 1 to 4: capture, adjust products, first sum, partials of t1 times contrast.
  always_ff @(posedge clk) begin
    s1_mn <= in_mn;
    s1_mx <= in_mx;
    for (int i = 0; i < NumChan; i++) begin
      s1_ch[i] <= in_ch[i];

      s2_ch[i]   <= s1_ch[i];
      s2_kmn[i]  <= adj[i] * $signed({1'b0, s1_mn});
      s2_kmx[i]  <= adj[i] * $signed({1'b0, s1_mx});
      s2_keep[i] <= (CHAN_MAX - alpha[0]) * s1_ch[i];

      s3_t1[i]   <= $signed({17'b0, s2_ch[i], 16'b0})
                    + $signed({s2_kmn[i][47], s2_kmn[i]});
      s3_kmx[i]  <= s2_kmx[i];
      s3_keep[i] <= s2_keep[i];

      s4_pp0[i]  <= $signed({1'b0, s3_t1[i][31:0]}) * contrast;
      s4_pp1[i]  <= $signed(s3_t1[i][48:32]) * contrast;
      s4_kmx[i]  <= s3_kmx[i];
      s4_keep[i] <= s3_keep[i];
    end
  end

  // Stages 5 to 7: add the max term, then multiply by contrast again in partials.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumChan; i++) begin
      s5_n2[i]   <= {{18{s4_pp0[i][63]}}, s4_pp0[i]}
                    + {s4_pp1[i][48], s4_pp1[i], 32'b0}
                    + {{18{s4_kmx[i][47]}}, s4_kmx[i], 16'b0}
                    ;
      s5_keep[i] <= s4_keep[i];

      s6_q0[i]   <= $signed({1'b0, s5_n2[i][31:0]}) * contrast;
      s6_q1[i]   <= $signed({1'b0, s5_n2[i][63:32]}) * contrast;
      s6_q2[i]   <= $signed(s5_n2[i][81:64]) * contrast;
      s6_keep[i] <= s5_keep[i];

      s7_n3[i]   <= {{50{s6_q0[i][63]}}, s6_q0[i]}
                    + {{18{s6_q1[i][63]}}, s6_q1[i], 32'b0}
                    + {s6_q2[i], 64'b0};
      s7_keep[i] <= s6_keep[i];
    end
  end

  // Stages 8 and 9: multiply by alpha in partials and fold in the kept share.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumChan; i++) begin
      s8_p0[i]   <= s7_n3[i][31:0] * alpha[6];
      s8_p1[i]   <= s7_n3[i][63:32] * alpha[6];
      s8_p2[i]   <= s7_n3[i][95:64] * alpha[6];
      s8_p3[i]   <= $signed(s7_n3[i][113:96]) * $signed({1'b0, alpha[6]});
      s8_keep[i] <= s7_keep[i];

      s9_lower[i] <= {34'b0, s8_p0[i]} + {2'b0, s8_p1[i], 32'b0}
                     + {2'b0, s8_keep[i], 48'b0};
      s9_upper[i] <= {s8_p3[i][34], s8_p3[i], 32'b0} + {20'b0, s8_p2[i]};
    end
  end

  // Stage 10: full numerator, sign and overflow flags, quotient source bits.
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      s10_n[i] = {s9_upper[i][63:0], 64'b0} + {46'b0, s9_lower[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumChan; i++) begin
      s10_neg[i] <= s10_n[i][127];
      s10_ovf[i] <= (s10_n[i][127:80] != '0) || (s10_n[i][79:64] == CHAN_MAX);
      s10_x[i]   <= s10_n[i][79:48];
    end
  end

  // Stage 11: divide by 65535 with one correction step, then saturate.
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      s11_q0[i]  = s10_x[i][31:16];
      s11_rem[i] = {1'b0, s10_x[i][15:0]} + {1'b0, s11_q0[i]};
      s11_q[i]   = s11_q0[i] + {15'b0, (s11_rem[i] >= {1'b0, CHAN_MAX})};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumChan; i++) begin
      priority if (s10_neg[i]) begin
        s11_res[i] <= '0;
      end else if (s10_ovf[i]) begin
        s11_res[i] <= CHAN_MAX;
      end else begin
        s11_res[i] <= s11_q[i];
      end
    end
  end

  // Result request.
  assign done             = vld[10];
  assign result.red_out   = s11_res[0];
  assign result.green_out = s11_res[1];
  assign result.blue_out  = s11_res[2];
  assign result.alpha_out = alpha[10];

endmodule

/* verif/moonlight_color_grade_pixel_checker.sv */
// Checker for the moonlight color grade pixel block: tracks settings, predicts and compares.
`timescale 1ns / 1ps

module moonlight_color_grade_pixel_checker
  import mcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  pixel_t             pixel,
  input  logic               done,
  input  result_t            result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatch_count,
  output int                 pending_count,
  output int                 results_checked
);

  // Local copy of the grading settings, all signed Q16.16.
  logic signed [31:0] red_adj;
  logic signed [31:0] green_adj;
  logic signed [31:0] blue_adj;
  logic signed [31:0] contrast_q;

  // Graded pixels predicted for requests the block has taken but not yet returned.
  result_t graded_pixels_due[$];

  // Exact grade of one channel: the weighted blend is formed as one wide integer
  // over the common denominator 65535 * 2^48, then truncated and clamped.
  function automatic logic [15:0] grade_channel_value(input logic [15:0] chan,
                                                      input logic signed [31:0] adj,
                                                      input logic [15:0] lo,
                                                      input logic [15:0] hi,
                                                      input logic [15:0] alpha);
    logic signed [127:0] ch_w, k_w, c_w, lo_w, hi_w, a_w, blend;
    logic [127:0] quot;
    ch_w = {112'd0, chan};
    k_w = adj;
    c_w = contrast_q;
    lo_w = {112'd0, lo};
    hi_w = {112'd0, hi};
    a_w = {112'd0, alpha};
    blend = c_w * ((ch_w <<< 16) + k_w * lo_w) + ((k_w * hi_w) <<< 16);
    blend = blend * c_w * a_w + (((128'sd65535 - a_w) * ch_w) <<< 48);
    // A negative blend truncates to zero or below, which clamps to black.
    if (blend < 0) return 16'd0;
    quot = unsigned'(blend) / ({112'd0, CHAN_MAX} << 48);
    if (quot > {112'd0, CHAN_MAX}) return CHAN_MAX;
    return quot[15:0];
  endfunction

  // Predicted output for one pixel under the current settings.
  function automatic result_t grade_pixel(input pixel_t px);
    result_t graded;
    logic [15:0] lo, hi;
    lo = px.red_in;
    hi = px.red_in;
    if (px.green_in > hi) hi = px.green_in;
    if (px.blue_in > hi) hi = px.blue_in;
    if (px.green_in < lo) lo = px.green_in;
    if (px.blue_in < lo) lo = px.blue_in;
    graded.red_out   = grade_channel_value(px.red_in, red_adj, lo, hi, px.alpha_in);
    graded.green_out = grade_channel_value(px.green_in, green_adj, lo, hi, px.alpha_in);
    graded.blue_out  = grade_channel_value(px.blue_in, blue_adj, lo, hi, px.alpha_in);
    graded.alpha_out = px.alpha_in;
    return graded;
  endfunction

  // Compares one output field and counts a mismatch.
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got, inout int errs);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errs++;
    end
  endtask

  // Results are compared before new requests are queued, so a result that
  // arrives with nothing outstanding is always caught.
  always @(posedge clk) begin
    result_t due;
    int errs;
    errs = 0;
    if (rst) begin
      red_adj <= '0;
      green_adj <= '0;
      blue_adj <= '0;
      contrast_q <= CONTRAST_RESET;
      graded_pixels_due.delete();
      mismatch_count <= 0;
      pending_count <= 0;
      results_checked <= 0;
    end else begin
      if (done) begin
        if (graded_pixels_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          errs++;
        end else begin
          due = graded_pixels_due.pop_front();
          check_field("red_out", due.red_out, result.red_out, errs);
          check_field("green_out", due.green_out, result.green_out, errs);
          check_field("blue_out", due.blue_out, result.blue_out, errs);
          check_field("alpha_out", due.alpha_out, result.alpha_out, errs);
          results_checked <= results_checked + 1;
        end
      end
      if (start && !busy) begin
        graded_pixels_due.push_back(grade_pixel(pixel));
      end
      // Writes to an index past the contrast register are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RED_ADJUST: begin
            red_adj <= cfg_data;
          end
          REG_GREEN_ADJUST: begin
            green_adj <= cfg_data;
          end
          REG_BLUE_ADJUST: begin
            blue_adj <= cfg_data;
          end
          REG_CONTRAST: begin
            contrast_q <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      mismatch_count <= mismatch_count + errs;
      pending_count <= graded_pixels_due.size();
    end
  end

endmodule

/* verif/tb_moonlight_color_grade_pixel.sv */
// Testbench top for the moonlight color grade pixel block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_moonlight_color_grade_pixel;
  import mcg_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettingsPerMode = 6;
  localparam int PixelsPerSetting = 105;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  pixel_t             pixel;
  logic               done;
  result_t            result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int pixels_sent;
  int cfg_writes;
  int sender_idle_pct;
  int stall_cycles;

  // Corner settings: red, green, blue adjust, then contrast.
  logic [31:0] corner_settings [4][4] = '{
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000},
    '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0000}
  };

  // Corner pixels: black, white, a saturated mix, transparent color, half alpha.
  pixel_t corner_pixels [5] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    {16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF},
    {16'h1234, 16'h0001, 16'hFFFF, 16'h0000},
    {16'h0123, 16'hFEDC, 16'h8000, 16'h8000}
  };

  moonlight_color_grade_pixel DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  moonlight_color_grade_pixel_checker grade_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .pixel           (pixel),
    .done            (done),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: ends the run after too many cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, pending_count);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // A random pixel, biased toward opaque, transparent, gray and clipped cases.
  function automatic pixel_t random_pixel();
    pixel_t px;
    px = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: begin
        px.alpha_in = 16'h0000;
      end
      1: begin
        px.alpha_in = CHAN_MAX;
      end
      2: begin
        px.green_in = px.red_in;
        px.blue_in = px.red_in;
      end
      3: begin
        px.red_in = $urandom_range(0, 1) ? CHAN_MAX : 16'h0000;
        px.green_in = $urandom_range(0, 1) ? CHAN_MAX : 16'h0000;
        px.blue_in = $urandom_range(0, 1) ? CHAN_MAX : 16'h0000;
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  // A random Q16.16 setting: mostly moderate, sometimes extreme or fully random.
  function automatic logic [31:0] random_setting(input bit for_contrast);
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: begin
        if (for_contrast) return $urandom_range(0, 32'h0003_0000);
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      end
    endcase
  endfunction

  // Offers one pixel request after a random number of idle cycles; returns
  // at the edge that takes it. Idle cycles carry noise on the pixel bus.
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      pixel <= {$urandom(), $urandom()};
    end
    @(negedge clk);
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
    pixels_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic write_settings(input logic [31:0] red, input logic [31:0] green,
                                input logic [31:0] blue, input logic [31:0] con);
    write_register(REG_RED_ADJUST, red);
    write_register(REG_GREEN_ADJUST, green);
    write_register(REG_BLUE_ADJUST, blue);
    write_register(REG_CONTRAST, con);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixels_sent = 0;
    cfg_writes = 0;
    sender_idle_pct = 14;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner pixels under the reset settings, where the grade is the identity.
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);

    // A write past the last register must leave the settings alone.
    wait_drained();
    write_register(CfgIdxW'($urandom_range(255, REG_CONTRAST + 1)), $urandom());
    write_register(8'hFF, $urandom());
    send_pixel(corner_pixels[4]);

    // Corner settings drive the blend to both clamps and through zero contrast.
    foreach (corner_settings[s]) begin
      wait_drained();
      write_settings(corner_settings[s][0], corner_settings[s][1],
                     corner_settings[s][2], corner_settings[s][3]);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    end

    // Random pixels under random settings, through three idle patterns.
    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 62 : 0;
      for (int s = 0; s < SettingsPerMode; s++) begin
        wait_drained();
        write_settings(random_setting(1'b0), random_setting(1'b0),
                       random_setting(1'b0), random_setting(1'b1));
        for (int i = 0; i < PixelsPerSetting; i++) begin
          if ($urandom_range(0, 63) == 0) wait_drained();
          send_pixel(random_pixel());
        end
      end
    end

    // Let the pipeline empty, then watch a little longer for stray results.
    wait_drained();
    repeat (24) @(posedge clk);

    $display("Run covered %0d pixel requests and %0d register writes;", pixels_sent,
             cfg_writes);
    $display("%0d graded pixels were compared across corner and random settings.",
             results_checked);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
